@@ design/cedr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command echo response deframer package
// Shared types, codes and sizing constants for the deframer modules.
// ----------------------------------------------------------------------------
package cedr_pkg;

	// Sizing of the response framing.
	localparam int HEADER_LEN  = 4;
	localparam int CMD_BYTES   = 4;
	localparam int MAX_PAYLOAD = 256;
	localparam int ECHO_LEN    = HEADER_LEN + CMD_BYTES;
	localparam int MPOS_W      = $clog2(ECHO_LEN);
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

	// Depth of the op queue and of the result queue.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd150;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BYTE  = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_BYTE,
		OP_TICK
	} op_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HUNT,
		PH_LEN,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TIMEOUT  = 2'd1,
		STATUS_ZERO_LEN = 2'd2,
		STATUS_TOO_BIG  = 2'd3
	} status_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [31:0] data;
	} op_t;

	typedef struct packed {
		logic [31:0] header;
		logic [15:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic        has_byte;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic        last;
		status_t     status;
		logic [15:0] resp_length;
	} result_t;

endpackage

@@ design/cedr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts input items, classifies the action and queues the resulting ops.
// ----------------------------------------------------------------------------
module cedr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        action,
	input  logic [7:0]        cmd_type,
	input  logic [7:0]        cmd_arg1,
	input  logic [15:0]       cmd_arg2,
	input  logic [7:0]        rx_byte,
	output logic              op_valid,
	output cedr_pkg::op_t     op,
	input  logic              op_pop
);
	import cedr_pkg::*;

	op_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	op_t              op_in;
	logic             keep;
	logic             wr_en;
	logic             rd_en;

	// Unused action codes are taken and dropped here.
	always_comb begin
		op_in = '{kind: OP_BYTE, data: {24'd0, rx_byte}};
		keep  = 1'b1;
		unique case (action_t'(action))
			ACT_START: op_in = '{kind: OP_START, data: {cmd_type, cmd_arg1, cmd_arg2}};
			ACT_BYTE:  op_in = '{kind: OP_BYTE, data: {24'd0, rx_byte}};
			ACT_TICK:  op_in = '{kind: OP_TICK, data: 32'd0};
			default:   keep  = 1'b0;
		endcase
	end

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign op_valid = (count_q != '0);
	assign op       = queue_q[rd_ptr_q];
	assign wr_en    = push && !full && keep;
	assign rd_en    = op_pop && op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= op_in;
		end
	end

endmodule

@@ design/cedr_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer engine
// Runs the hunt, length and payload phases, one op per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module cedr_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  cedr_pkg::cfg_t    cfg,
	input  logic              op_valid,
	input  cedr_pkg::op_t     op,
	output logic              op_pop,
	input  logic              res_full,
	output logic              res_push,
	output cedr_pkg::result_t res
);
	import cedr_pkg::*;

	function automatic logic [7:0] echo_byte(input logic [MPOS_W-1:0] pos,
		input logic [31:0] hdr, input logic [31:0] cmd);
		logic [1:0] slot;
		logic [7:0] b;
		if (32'(pos) < HEADER_LEN) begin
			slot = 2'(pos);
			b    = hdr[8 * (3 - slot) +: 8];
		end else begin
			slot = 2'(32'(pos) - HEADER_LEN);
			b    = cmd[8 * (3 - slot) +: 8];
		end
		return b;
	endfunction

	phase_t            phase_q, phase_d;
	logic [MPOS_W-1:0] match_pos_q, match_pos_d;
	logic [31:0]       cmd_q, cmd_d;
	logic [7:0]        length_high_q, length_high_d;
	logic [LEN_W-1:0]  expected_q, expected_d;
	logic [LEN_W-1:0]  byte_index_q, byte_index_d;
	logic [15:0]       tick_q, tick_d;

	logic [7:0]        rx;
	logic              echo_hit;
	logic              first_hit;
	logic [MPOS_W:0]   match_next;
	logic              echo_done;
	logic              len_second;
	logic [15:0]       len_full;
	logic              len_zero;
	logic              len_big;
	logic [LEN_W-1:0]  idx_next;
	logic              data_done;
	logic [15:0]       tick_next;
	logic              tick_expired;

	assign op_pop       = op_valid && !res_full;
	assign rx           = op.data[7:0];
	assign echo_hit     = (rx == echo_byte(match_pos_q, cfg.header, cmd_q));
	assign first_hit    = (rx == echo_byte('0, cfg.header, cmd_q));
	assign match_next   = {1'b0, match_pos_q} + 1'b1;
	assign echo_done    = (match_next == (MPOS_W + 1)'(ECHO_LEN));
	assign len_second   = match_pos_q[0];
	assign len_full     = {length_high_q, rx};
	assign len_zero     = (len_full == 16'd0);
	assign len_big      = (32'(len_full) > MAX_PAYLOAD);
	assign idx_next     = byte_index_q + 1'b1;
	assign data_done    = (idx_next >= expected_q);
	assign tick_next    = tick_q + 16'd1;
	assign tick_expired = (tick_next >= cfg.timeout_limit);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (op_pop) begin
			unique case (op.kind)
				OP_START: phase_d = PH_HUNT;
				OP_TICK: begin
					if (phase_q != PH_IDLE && tick_expired) begin
						phase_d = PH_IDLE;
					end
				end
				OP_BYTE: begin
					unique case (phase_q)
						PH_HUNT: begin
							if (echo_hit && echo_done) begin
								phase_d = PH_LEN;
							end
						end
						PH_LEN: begin
							if (len_second) begin
								phase_d = (len_zero || len_big) ? PH_IDLE : PH_DATA;
							end
						end
						PH_DATA: begin
							if (data_done) begin
								phase_d = PH_IDLE;
							end
						end
						default: phase_d = phase_q;
					endcase
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// Datapath registers and result.
	always_comb begin
		match_pos_d   = match_pos_q;
		cmd_d         = cmd_q;
		length_high_d = length_high_q;
		expected_d    = expected_q;
		byte_index_d  = byte_index_q;
		tick_d        = tick_q;
		res_push      = 1'b0;
		res           = '0;
		if (op_pop) begin
			case (op.kind)
				OP_START: begin
					cmd_d         = op.data;
					match_pos_d   = '0;
					length_high_d = '0;
					expected_d    = '0;
					byte_index_d  = '0;
					tick_d        = '0;
				end
				OP_TICK: begin
					if (phase_q != PH_IDLE) begin
						tick_d = tick_next;
						if (tick_expired) begin
							res_push   = 1'b1;
							res.last   = 1'b1;
							res.status = STATUS_TIMEOUT;
						end
					end
				end
				OP_BYTE: begin
					case (phase_q)
						PH_HUNT: begin
							if (echo_hit) begin
								match_pos_d = echo_done ? '0 : MPOS_W'(match_next);
							end else if (first_hit) begin
								match_pos_d = MPOS_W'(1);
							end else begin
								match_pos_d = '0;
							end
						end
						PH_LEN: begin
							if (!len_second) begin
								length_high_d = rx;
								match_pos_d   = MPOS_W'(1);
							end else begin
								match_pos_d = '0;
								expected_d  = LEN_W'(len_full);
								if (len_zero) begin
									res_push   = 1'b1;
									res.last   = 1'b1;
									res.status = STATUS_ZERO_LEN;
								end else if (len_big) begin
									res_push        = 1'b1;
									res.last        = 1'b1;
									res.status      = STATUS_TOO_BIG;
									res.resp_length = len_full;
								end else begin
									byte_index_d = '0;
								end
							end
						end
						PH_DATA: begin
							byte_index_d      = idx_next;
							res_push          = 1'b1;
							res.has_byte      = 1'b1;
							res.payload_byte  = rx;
							res.payload_index = 8'(byte_index_q);
							res.status        = STATUS_OK;
							if (data_done) begin
								res.last        = 1'b1;
								res.resp_length = 16'(expected_q);
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			match_pos_q   <= '0;
			cmd_q         <= '0;
			length_high_q <= '0;
			expected_q    <= '0;
			byte_index_q  <= '0;
			tick_q        <= '0;
		end else begin
			phase_q       <= phase_d;
			match_pos_q   <= match_pos_d;
			cmd_q         <= cmd_d;
			length_high_q <= length_high_d;
			expected_q    <= expected_d;
			byte_index_q  <= byte_index_d;
			tick_q        <= tick_d;
		end
	end

endmodule

@@ design/cedr_result_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module cedr_result_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_push,
	input  cedr_pkg::result_t res,
	output logic              res_full,
	output logic              empty,
	input  logic              pop,
	output cedr_pkg::result_t head
);
	import cedr_pkg::*;

	result_t           queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              wr_en;
	logic              rd_en;

	assign res_full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head     = queue_q[rd_ptr_q];
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

endmodule

@@ design/command_echo_response_deframer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command echo response deframer unit
// An accepted item is registered in the op queue; the engine reads the op at
// the head of the op queue and writes the result into the result queue in
// the same cycle, as long as that queue has room. The result ports show the
// head of the result queue.
// Throughput: one item per cycle; the engine retires one op each cycle as
// long as the result queue has room.
// Reset: arst_n clears both queues, the engine state and the registers
// (header 0, timeout limit 150); no clearing pass is needed.
// ----------------------------------------------------------------------------
module command_echo_response_deframer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input item channel.
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      action,
	input  logic [7:0]                      cmd_type,
	input  logic [7:0]                      cmd_arg1,
	input  logic [15:0]                     cmd_arg2,
	input  logic [7:0]                      rx_byte,
	// Result item channel.
	output logic                            empty,
	input  logic                            pop,
	output logic                            has_byte,
	output logic [7:0]                      payload_byte,
	output logic [7:0]                      payload_index,
	output logic                            last,
	output logic [1:0]                      status,
	output logic [15:0]                     resp_length,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cedr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);
	import cedr_pkg::*;

	logic [31:0] header_q;
	logic [15:0] timeout_limit_q;
	cfg_t        cfg;
	logic        op_valid;
	op_t         op;
	logic        op_pop;
	logic        res_push;
	logic        res_full;
	result_t     res;
	result_t     head;

	// Registers are always ready to take a write. Writes to an index that
	// names no register are accepted and dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q        <= '0;
			timeout_limit_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER:  header_q        <= cfg_data;
				REG_TIMEOUT: timeout_limit_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = '{header: header_q, timeout_limit: timeout_limit_q};

	// The front end classifies each item and parks it in the op queue, so
	// input acceptance only stalls when that queue fills up.
	cedr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.action   (action),
		.cmd_type (cmd_type),
		.cmd_arg1 (cmd_arg1),
		.cmd_arg2 (cmd_arg2),
		.rx_byte  (rx_byte),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop)
	);

	// The engine holds the transaction state and emits at most one result
	// for each op it retires.
	cedr_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// Results wait here for the consumer, decoupling the engine from pop.
	cedr_result_queue u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign has_byte      = head.has_byte;
	assign payload_byte  = head.payload_byte;
	assign payload_index = head.payload_index;
	assign last          = head.last;
	assign status        = head.status;
	assign resp_length   = head.resp_length;

endmodule

@@ tb/tb_command_echo_response_deframer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the command echo response deframer unit
// Sends start, byte and tick items through the input queue and compares each
// result item against an in-bench model of the deframer. A short directed
// table covers the idle cases, the error endings and the register extremes;
// random well-formed exchanges with noise, corruption and ticks follow,
// across several header and timeout settings.
// ----------------------------------------------------------------------------
module tb_command_echo_response_deframer_unit;
	import cedr_pkg::*;

	// The action port is two bits wide, so code 3 can be driven; it is unused.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// Register indexes beyond the two real registers; writes to them are ignored.
	localparam logic [CFG_IDX_W-1:0] REG_NONE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_3 = 2'd3;

	localparam int ITEM_TARGET    = 1900;
	localparam int QUIET_ITEMS    = 200;
	localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 4;
	localparam int WATCHDOG_LIMIT = 2000;

	// One input item as the ports carry it.
	typedef struct packed {
		logic [1:0]  act;
		logic [7:0]  typ;
		logic [7:0]  arg1;
		logic [15:0] arg2;
		logic [7:0]  rx;
	} in_item_t;

	// One row of the directed table: either a register write or an item,
	// the latter optionally with its result written out by hand.
	typedef struct packed {
		logic                 is_reg;
		logic                 typed;
		in_item_t             item;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [31:0]          reg_val;
		result_t              want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        push = 1'b0;
	logic        full;
	logic [1:0]  action = 2'd0;
	logic [7:0]  cmd_type = 8'd0;
	logic [7:0]  cmd_arg1 = 8'd0;
	logic [15:0] cmd_arg2 = 16'd0;
	logic [7:0]  rx_byte = 8'd0;

	logic        empty;
	logic        pop = 1'b0;
	logic        has_byte;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic        last;
	logic [1:0]  status;
	logic [15:0] resp_length;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = 32'd0;

	command_echo_response_deframer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.cmd_type     (cmd_type),
		.cmd_arg1     (cmd_arg1),
		.cmd_arg2     (cmd_arg2),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.has_byte     (has_byte),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.last         (last),
		.status       (status),
		.resp_length  (resp_length),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model state, mirroring what the deframer holds after reset.
	logic [31:0] cfg_header = 32'd0;
	logic [15:0] cfg_limit = TIMEOUT_RESET;
	phase_t      pr_phase = PH_IDLE;
	logic [3:0]  pr_pos = '0;
	logic [31:0] pr_cmd = '0;
	logic [7:0]  pr_len_hi = '0;
	logic [15:0] pr_len = '0;
	logic [15:0] pr_count = '0;
	logic [15:0] pr_ticks = '0;

	result_t     results_due[$];
	script_row_t script[$];
	int          mismatches = 0;
	int          busy_items = 0;
	int          tick_odds = 20;
	bit          quiet = 1'b0;

	function automatic result_t make_result(logic has, logic [7:0] b, logic [7:0] idx,
		logic fin, status_t st, logic [15:0] len);
		result_t r;
		r.has_byte = has;
		r.payload_byte = b;
		r.payload_index = idx;
		r.last = fin;
		r.status = st;
		r.resp_length = len;
		return r;
	endfunction

	// Advances the model by one accepted item; returns 1 when the item yields
	// a result, which is then placed in res.
	function automatic bit deframe_step(input in_item_t it, output result_t res);
		logic [63:0] seq;
		logic [7:0]  want_byte;
		logic [7:0]  first_byte;
		logic [15:0] idx;
		res = '0;
		if (it.act == ACT_START) begin
			pr_cmd = {it.typ, it.arg1, it.arg2};
			pr_phase = PH_HUNT;
			pr_pos = '0;
			pr_len_hi = '0;
			pr_len = '0;
			pr_count = '0;
			pr_ticks = '0;
			return 1'b0;
		end
		if (it.act == ACT_TICK) begin
			if (pr_phase == PH_IDLE)
				return 1'b0;
			pr_ticks = pr_ticks + 16'd1;
			if (pr_ticks >= cfg_limit) begin
				pr_phase = PH_IDLE;
				res = make_result(1'b0, 8'd0, 8'd0, 1'b1, STATUS_TIMEOUT, 16'd0);
				return 1'b1;
			end
			return 1'b0;
		end
		if (it.act != ACT_BYTE || pr_phase == PH_IDLE)
			return 1'b0;

		case (pr_phase)
			PH_HUNT: begin
				// The echo is the header, first byte on top, then the command word.
				seq = {cfg_header, pr_cmd};
				want_byte = seq[63 - 8 * pr_pos -: 8];
				first_byte = seq[63:56];
				if (it.rx == want_byte) begin
					pr_pos = pr_pos + 4'd1;
					if (pr_pos >= ECHO_LEN) begin
						pr_phase = PH_LEN;
						pr_pos = '0;
					end
				end else if (it.rx == first_byte) begin
					pr_pos = 4'd1;
				end else begin
					pr_pos = '0;
				end
				return 1'b0;
			end
			PH_LEN: begin
				if (pr_pos == 0) begin
					pr_len_hi = it.rx;
					pr_pos = 4'd1;
					return 1'b0;
				end
				pr_pos = '0;
				pr_len = {pr_len_hi, it.rx};
				if (pr_len == 0) begin
					pr_phase = PH_IDLE;
					res = make_result(1'b0, 8'd0, 8'd0, 1'b1, STATUS_ZERO_LEN, 16'd0);
					return 1'b1;
				end
				if (pr_len > MAX_PAYLOAD) begin
					pr_phase = PH_IDLE;
					res = make_result(1'b0, 8'd0, 8'd0, 1'b1, STATUS_TOO_BIG, pr_len);
					return 1'b1;
				end
				pr_phase = PH_DATA;
				pr_count = '0;
				return 1'b0;
			end
			default: begin
				idx = pr_count;
				pr_count = pr_count + 16'd1;
				if (pr_count >= pr_len) begin
					pr_phase = PH_IDLE;
					res = make_result(1'b1, it.rx, idx[7:0], 1'b1, STATUS_OK, pr_len);
				end else begin
					res = make_result(1'b1, it.rx, idx[7:0], 1'b0, STATUS_OK, 16'd0);
				end
				return 1'b1;
			end
		endcase
	endfunction

	// Offers one item, optionally after a burst of idle cycles, and waits until
	// it is taken. The model runs at the accepting edge. A typed row supplies
	// its own expected result in place of the model's.
	task automatic send_item(input in_item_t it, input bit typed, input result_t want);
		result_t predicted;
		bit      yields;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		action <= it.act;
		cmd_type <= it.typ;
		cmd_arg1 <= it.arg1;
		cmd_arg2 <= it.arg2;
		rx_byte <= it.rx;
		do @(posedge clk); while (full);
		// Items that the idle block merely drops do not count toward the target.
		if (pr_phase != PH_IDLE || it.act == ACT_START)
			busy_items++;
		yields = deframe_step(it, predicted);
		if (typed)
			results_due.push_back(want);
		else if (yields)
			results_due.push_back(predicted);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HEADER:  cfg_header = val;
			REG_TIMEOUT: cfg_limit = val[15:0];
			default:     ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Brings the block to rest: stop offering items, wait for every expected
	// result, then give the ops that yield nothing time to leave the queue.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic maybe_tick();
		in_item_t it;
		if ($urandom_range(0, tick_odds) == 0) begin
			it = '0;
			it.act = ACT_TICK;
			it.rx = 8'($urandom_range(0, 255));
			send_item(it, 1'b0, '0);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_item_t it;
		maybe_tick();
		it = '0;
		it.act = ACT_BYTE;
		it.typ = 8'($urandom_range(0, 255));
		it.arg1 = 8'($urandom_range(0, 255));
		it.arg2 = 16'($urandom_range(0, 65535));
		it.rx = b;
		send_item(it, 1'b0, '0);
	endtask

	// One exchange: a start, some stray bytes, the echo (now and then with a
	// corrupted byte), the length and the payload. A negative forced_len picks
	// the length at random. Now and then the payload is cut short, so that the
	// next start lands while the block is still busy.
	task automatic random_exchange(input int forced_len);
		in_item_t    it;
		logic [63:0] echo_seq;
		logic [7:0]  b;
		logic [15:0] len_word;
		int          len;
		int          cut;
		int          n;
		if ($urandom_range(0, 9) == 0) begin
			it.typ = 8'($urandom_range(0, 255));
			it.arg1 = 8'($urandom_range(0, 255));
			it.arg2 = 16'($urandom_range(0, 65535));
			it.rx = 8'($urandom_range(0, 255));
			case ($urandom_range(0, 2))
				0:       it.act = ACT_BYTE;
				1:       it.act = ACT_TICK;
				default: it.act = ACT_SPARE;
			endcase
			send_item(it, 1'b0, '0);
		end

		it.act = ACT_START;
		it.typ = 8'($urandom_range(0, 255));
		it.arg1 = 8'($urandom_range(0, 255));
		it.arg2 = 16'($urandom_range(0, 65535));
		it.rx = 8'($urandom_range(0, 255));
		send_item(it, 1'b0, '0);
		echo_seq = {cfg_header, it.typ, it.arg1, it.arg2};

		// Stray bytes before the echo; half of them look like the first header
		// byte, and a few carry the unused action code.
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) begin
			if ($urandom_range(0, 3) == 0) begin
				it.act = ACT_SPARE;
				it.rx = 8'($urandom_range(0, 255));
				send_item(it, 1'b0, '0);
			end else begin
				send_byte($urandom_range(0, 1) ? echo_seq[63:56] : 8'($urandom_range(0, 255)));
			end
		end

		for (int k = 0; k < ECHO_LEN; k++) begin
			b = echo_seq[63 - 8 * k -: 8];
			if ($urandom_range(0, 39) == 0)
				b = 8'($urandom_range(0, 255));
			send_byte(b);
		end

		if (forced_len >= 0) begin
			len = forced_len;
		end else begin
			case ($urandom_range(0, 19))
				0:       len = 0;
				1:       len = $urandom_range(MAX_PAYLOAD + 1, 65535);
				2:       len = MAX_PAYLOAD + 1;
				3:       len = $urandom_range(13, MAX_PAYLOAD);
				default: len = $urandom_range(1, 12);
			endcase
		end
		len_word = len[15:0];
		send_byte(len_word[15:8]);
		send_byte(len_word[7:0]);

		if (len >= 1 && len <= MAX_PAYLOAD) begin
			cut = len;
			if ($urandom_range(0, 29) == 0)
				cut = $urandom_range(0, len - 1);
			repeat (cut) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	function automatic script_row_t item_row(logic [1:0] act, logic [7:0] typ,
		logic [7:0] a1, logic [15:0] a2, logic [7:0] rx);
		script_row_t r;
		r = '0;
		r.item.act = act;
		r.item.typ = typ;
		r.item.arg1 = a1;
		r.item.arg2 = a2;
		r.item.rx = rx;
		return r;
	endfunction

	function automatic script_row_t checked_row(logic [1:0] act, logic [7:0] rx, result_t want);
		script_row_t r;
		r = item_row(act, 8'd0, 8'd0, 16'd0, rx);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		script_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// The result side stalls in random bursts, except in the closing stretch
	// of the run.
	int pop_hold = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop_hold = pop_hold - 1;
			pop <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			pop_hold = $urandom_range(0, 8);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Every result taken is matched against the oldest outstanding expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (results_due.size() == 0) begin
				$display("%0t: result with nothing expected, has_byte %0h last %0h status %0h",
					$time, has_byte, last, status);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("has_byte", 16'(want.has_byte), 16'(has_byte));
				check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
				check_field("payload_index", 16'(want.payload_index), 16'(payload_index));
				check_field("last", 16'(want.last), 16'(last));
				check_field("status", 16'(want.status), 16'(status));
				check_field("resp_length", want.resp_length, resp_length);
			end
		end
	end

	// The run is stuck if nothing at all is taken for this many cycles.
	int stuck_cycles = 0;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles = stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [7:0]  hb;
		logic [7:0]  odd_byte;
		logic [31:0] hdr;
		logic [15:0] lim;
		int          phase_no;
		bit          long_done;

		// Directed table. Under the reset header of all zeros the echo is four
		// zero bytes and then the command.
		// Bytes, ticks and the unused action code are all dropped while idle.
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'h55));
		script.push_back(item_row(ACT_TICK, 8'h00, 8'h00, 16'h0000, 8'h00));
		script.push_back(item_row(ACT_SPARE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF));
		// A second start while hunting replaces the first command silently.
		script.push_back(item_row(ACT_START, 8'hFF, 8'h00, 16'hFFFF, 8'h00));
		script.push_back(item_row(ACT_START, 8'h00, 8'hFF, 16'h0000, 8'h00));
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'h00));
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'h00));
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'h00));
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'h00));
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'h00));
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'hFF));
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'h00));
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'h00));
		// A zero length ends the exchange with an error.
		script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'h00));
		script.push_back(checked_row(ACT_BYTE, 8'h00,
			make_result(1'b0, 8'h00, 8'h00, 1'b1, STATUS_ZERO_LEN, 16'h0000)));
		// With a limit of zero the very first tick times out.
		script.push_back(reg_row(REG_TIMEOUT, 32'd0));
		script.push_back(item_row(ACT_START, 8'h12, 8'h34, 16'h5678, 8'h00));
		script.push_back(checked_row(ACT_TICK, 8'h00,
			make_result(1'b0, 8'h00, 8'h00, 1'b1, STATUS_TIMEOUT, 16'h0000)));
		// All-ones header and command, largest limit, and a write to an index
		// that holds no register.
		script.push_back(reg_row(REG_HEADER, 32'hFFFF_FFFF));
		script.push_back(reg_row(REG_TIMEOUT, 32'h0000_FFFF));
		script.push_back(reg_row(REG_NONE_2, 32'hFFFF_FFFF));
		script.push_back(item_row(ACT_START, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF));
		repeat (ECHO_LEN + 1)
			script.push_back(item_row(ACT_BYTE, 8'h00, 8'h00, 16'h0000, 8'hFF));
		// A length of 0xFFFF is far above the payload limit.
		script.push_back(checked_row(ACT_BYTE, 8'hFF,
			make_result(1'b0, 8'h00, 8'h00, 1'b1, STATUS_TOO_BIG, 16'hFFFF)));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				settle();
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				send_item(script[i].item, script[i].typed, script[i].want);
			end
		end

		// Random part: each setting is held for a batch of exchanges. The
		// header patterns with repeated bytes stress the restart rule of the
		// hunt; the small limits make timeouts common.
		phase_no = 0;
		long_done = 1'b0;
		while (busy_items < ITEM_TARGET) begin
			hb = 8'($urandom_range(0, 255));
			odd_byte = 8'($urandom_range(0, 255));
			case (phase_no % 6)
				0: begin
					hdr = $urandom;
					lim = TIMEOUT_RESET;
					tick_odds = 20;
				end
				1: begin
					hdr = 32'hFFFF_FFFF;
					lim = 16'hFFFF;
					tick_odds = 8;
				end
				2: begin
					hdr = {4{hb}};
					lim = 16'($urandom_range(2, 10));
					tick_odds = 15;
				end
				3: begin
					hdr = 32'd0;
					lim = 16'd1;
					tick_odds = 60;
				end
				4: begin
					hdr = $urandom;
					lim = 16'($urandom_range(20, 400));
					tick_odds = 10;
				end
				default: begin
					hdr = {hb, hb, odd_byte, hb};
					lim = 16'd0;
					tick_odds = 80;
				end
			endcase
			settle();
			write_reg(REG_HEADER, hdr);
			write_reg(REG_TIMEOUT, {16'd0, lim});
			if (phase_no % 6 == 2)
				write_reg(REG_NONE_2, $urandom);
			if (phase_no % 6 == 5)
				write_reg(REG_NONE_3, $urandom);

			for (int k = 0; k < 10 && busy_items < ITEM_TARGET; k++) begin
				quiet = (busy_items >= ITEM_TARGET - QUIET_ITEMS);
				// One full-size payload per run walks the index up to 255.
				if (!long_done && phase_no % 6 == 1) begin
					long_done = 1'b1;
					random_exchange(MAX_PAYLOAD);
				end else begin
					random_exchange(-1);
				end
			end
			phase_no++;
		end

		quiet = 1'b1;
		settle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
